### design/uer_pkg.sv
package uer_pkg;

    localparam int TIMER_WIDTH = 22;
    localparam int TRIG_WIDTH  = 8;
    localparam int CFG_WIDTH   = TIMER_WIDTH;
    localparam int CFG_IDX_W   = 2;
    localparam int DIST_WIDTH  = 16;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [TRIG_WIDTH-1:0]  COUNT_MAX = {TRIG_WIDTH{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TO   = 2'd3;

    localparam logic [TRIG_WIDTH-1:0]  RST_TRIG_LOW  = 8'd2;
    localparam logic [TRIG_WIDTH-1:0]  RST_TRIG_HIGH = 8'd10;
    localparam logic [TIMER_WIDTH-1:0] RST_ECHO_TO   = 22'd39000;
    localparam logic [TIMER_WIDTH-1:0] RST_IDLE_TO   = 22'd3801000;

    // Distance is width * 17 / 1000. Widths at or above SAT_PULSE give more
    // than the 16-bit maximum. Below it, width * 17 / 8 fits in Y_WIDTH bits
    // and is then divided by 125 with a reciprocal and one correction step.
    localparam int SCALE_NUM   = 17;
    localparam int SCALE_DEN   = 1000;
    localparam int SAT_PULSE   = ((1 << DIST_WIDTH) * SCALE_DEN + SCALE_NUM - 1) / SCALE_NUM;
    localparam int PRE_SHIFT   = 3;
    localparam int DIVISOR     = SCALE_DEN >> PRE_SHIFT;
    localparam int Y_WIDTH     = 23;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
    localparam int PROD_W      = Y_WIDTH + RECIP_W;
    localparam int Q_WIDTH     = PROD_W - RECIP_SHIFT;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_LOW     = 4'b0010,
        PH_HIGH    = 4'b0100,
        PH_MEASURE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                   trig;
        logic                   done;
        logic                   tout;
        logic                   report;
        logic [TIMER_WIDTH-1:0] width;
    } t_step;

endpackage

### design/ultrasonic_echo_ranger_unit.sv
// An accepted word is registered with its step, then passes through the distance stages.
// Throughput: one word per cycle while the output is not stalled; the measurement
// state updates on the accepting edge and the distance divide runs in a three-stage
// pipeline behind it. The whole pipeline holds while the output word is stalled.
// Reset (synchronous, active low) clears the pipeline, returns the sequencer to idle
// and loads the registers with 2, 10, 39000 and 3801000.
module ultrasonic_echo_ranger_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_tick,
    input  logic                                 i_start_req,
    input  logic                                 i_echo,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_trig,
    output logic                                 o_done_res,
    output logic                                 o_expired,
    output logic [uer_pkg::DIST_WIDTH-1:0]       o_distance_cm,
    input  logic                                 i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [uer_pkg::CFG_WIDTH-1:0]        i_cfg_data
);

    logic           adv;
    logic           accept;
    logic           s1_valid;
    uer_pkg::t_step s1_step;

    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept     = i_in_valid && adv;

    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_accept    (accept),
        .i_tick      (i_tick),
        .i_start_req (i_start_req),
        .i_echo      (i_echo),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (s1_valid),
        .o_step      (s1_step)
    );

    uer_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (s1_valid),
        .i_step        (s1_step),
        .o_valid       (o_out_valid),
        .o_trig        (o_trig),
        .o_done_res    (o_done_res),
        .o_expired     (o_expired),
        .o_distance_cm (o_distance_cm)
    );

endmodule

### design/uer_ctrl.sv
module uer_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_accept,
    input  logic                                 i_tick,
    input  logic                                 i_start_req,
    input  logic                                 i_echo,
    input  logic                                 i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [uer_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    output logic                                 o_valid,
    output uer_pkg::t_step                       o_step
);

    logic [uer_pkg::TRIG_WIDTH-1:0]  r_trig_low;
    logic [uer_pkg::TRIG_WIDTH-1:0]  r_trig_high;
    logic [uer_pkg::TIMER_WIDTH-1:0] r_echo_to;
    logic [uer_pkg::TIMER_WIDTH-1:0] r_idle_to;

    uer_pkg::t_phase                 r_phase, n_phase;
    logic [uer_pkg::TRIG_WIDTH-1:0]  r_count, n_count;
    logic [uer_pkg::TIMER_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [uer_pkg::TIMER_WIDTH-1:0] r_pulse, n_pulse;
    logic                            r_seen, n_seen;

    logic                            r_valid;
    uer_pkg::t_step                  r_step;

    logic [uer_pkg::TRIG_WIDTH-1:0]  cnt_inc;
    logic [uer_pkg::TRIG_WIDTH-1:0]  limit;
    logic [uer_pkg::TIMER_WIDTH-1:0] el_inc;
    logic                            sat;
    logic                            done;
    logic                            tout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_low  <= uer_pkg::RST_TRIG_LOW;
            r_trig_high <= uer_pkg::RST_TRIG_HIGH;
            r_echo_to   <= uer_pkg::RST_ECHO_TO;
            r_idle_to   <= uer_pkg::RST_IDLE_TO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                uer_pkg::REG_TRIG_LOW:  r_trig_low  <= i_cfg_data[uer_pkg::TRIG_WIDTH-1:0];
                uer_pkg::REG_TRIG_HIGH: r_trig_high <= i_cfg_data[uer_pkg::TRIG_WIDTH-1:0];
                uer_pkg::REG_ECHO_TO:   r_echo_to   <= i_cfg_data[uer_pkg::TIMER_WIDTH-1:0];
                uer_pkg::REG_IDLE_TO:   r_idle_to   <= i_cfg_data[uer_pkg::TIMER_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_elapsed = r_elapsed;
        n_pulse   = r_pulse;
        n_seen    = r_seen;
        done      = 1'b0;
        tout      = 1'b0;
        cnt_inc   = (r_count == uer_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
        limit     = (r_phase == uer_pkg::PH_LOW) ? r_trig_low : r_trig_high;
        el_inc    = (r_elapsed == uer_pkg::TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
        sat       = (el_inc == uer_pkg::TIMER_MAX);
        if (i_accept) begin
            case (r_phase)
                uer_pkg::PH_IDLE: begin
                    if (i_start_req) begin
                        n_phase = uer_pkg::PH_LOW;
                        n_count = '0;
                    end
                end
                uer_pkg::PH_LOW, uer_pkg::PH_HIGH: begin
                    if (i_tick) begin
                        n_count = cnt_inc;
                        if (cnt_inc >= limit) begin
                            n_count = '0;
                            if (r_phase == uer_pkg::PH_LOW) begin
                                n_phase = uer_pkg::PH_HIGH;
                            end else begin
                                n_phase   = uer_pkg::PH_MEASURE;
                                n_elapsed = '0;
                                n_pulse   = '0;
                                n_seen    = 1'b0;
                            end
                        end
                    end
                end
                uer_pkg::PH_MEASURE: begin
                    if (i_tick) begin
                        n_elapsed = el_inc;
                        if (i_echo) begin
                            if (!r_seen) begin
                                n_seen  = 1'b1;
                                n_pulse = uer_pkg::TIMER_WIDTH'(1);
                                tout    = sat;
                            end else begin
                                if (r_pulse != uer_pkg::TIMER_MAX) begin
                                    n_pulse = r_pulse + 1'b1;
                                end
                                tout = sat || (el_inc >= r_echo_to);
                            end
                        end else begin
                            if (sat || (el_inc >= r_idle_to)) begin
                                tout = 1'b1;
                            end else if (r_seen) begin
                                done = 1'b1;
                            end
                        end
                        if (tout) begin
                            done = 1'b1;
                        end
                        if (done) begin
                            n_phase = uer_pkg::PH_IDLE;
                            n_count = '0;
                            n_seen  = 1'b0;
                        end
                    end
                end
                default: n_phase = uer_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= uer_pkg::PH_IDLE;
            r_count   <= '0;
            r_elapsed <= '0;
            r_pulse   <= '0;
            r_seen    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_pulse   <= n_pulse;
            r_seen    <= n_seen;
            if (i_adv) begin
                r_valid <= i_accept;
            end
        end
    end

    // The pulse width only matters on a clean finish, where the echo was low
    // and the width did not change on this word.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_step.trig   <= (n_phase == uer_pkg::PH_HIGH);
            r_step.done   <= done;
            r_step.tout   <= tout;
            r_step.report <= done && !tout;
            r_step.width  <= r_pulse;
        end
    end

    assign o_valid = r_valid;
    assign o_step  = r_step;

endmodule

### design/uer_dist.sv
module uer_dist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  uer_pkg::t_step                   i_step,
    output logic                             o_valid,
    output logic                             o_trig,
    output logic                             o_done_res,
    output logic                             o_expired,
    output logic [uer_pkg::DIST_WIDTH-1:0]   o_distance_cm
);

    localparam int SCALED_W = uer_pkg::TIMER_WIDTH + 5;

    typedef struct packed {
        logic trig;
        logic done;
        logic tout;
        logic report;
        logic sat;
    } t_flags;

    logic                             r_v2, r_v3, r_v4;
    t_flags                           r_f2, r_f3;
    logic [uer_pkg::Y_WIDTH-1:0]      r_y2, r_y3;
    logic [uer_pkg::Q_WIDTH-1:0]      r_q3;
    logic                             r_trig4, r_done4, r_tout4;
    logic [uer_pkg::DIST_WIDTH-1:0]   r_dist4;

    logic [SCALED_W-1:0]              scaled;
    logic [uer_pkg::PROD_W-1:0]       prod;
    logic [uer_pkg::Q_WIDTH+6:0]      qmul;
    logic [uer_pkg::Y_WIDTH-1:0]      rem;
    logic [uer_pkg::Q_WIDTH-1:0]      quot;
    t_flags                           f1;

    // Width times 17 as a shift and add, then the divide by 8 of the 1000.
    assign scaled = (SCALED_W'(i_step.width) << 4) + SCALED_W'(i_step.width);

    always_comb begin
        f1.trig   = i_step.trig;
        f1.done   = i_step.done;
        f1.tout   = i_step.tout;
        f1.report = i_step.report;
        f1.sat    = (32'(i_step.width) >= uer_pkg::SAT_PULSE);
    end

    assign prod = uer_pkg::PROD_W'(r_y2) * uer_pkg::PROD_W'(uer_pkg::RECIP);

    // The reciprocal estimate is exact or one short; one remainder check
    // puts it right.
    assign qmul = (uer_pkg::Q_WIDTH+7)'(r_q3) * (uer_pkg::Q_WIDTH+7)'(uer_pkg::DIVISOR);
    assign rem  = r_y3 - qmul[uer_pkg::Y_WIDTH-1:0];
    assign quot = (32'(rem) >= uer_pkg::DIVISOR) ? r_q3 + 1'b1 : r_q3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_f2    <= f1;
            r_y2    <= scaled[uer_pkg::PRE_SHIFT +: uer_pkg::Y_WIDTH];
            r_f3    <= r_f2;
            r_y3    <= r_y2;
            r_q3    <= prod[uer_pkg::PROD_W-1:uer_pkg::RECIP_SHIFT];
            r_trig4 <= r_f3.trig;
            r_done4 <= r_f3.done;
            r_tout4 <= r_f3.tout;
            if (!r_f3.report) begin
                r_dist4 <= '0;
            end else if (r_f3.sat) begin
                r_dist4 <= '1;
            end else begin
                r_dist4 <= quot[uer_pkg::DIST_WIDTH-1:0];
            end
        end
    end

    assign o_valid       = r_v4;
    assign o_trig        = r_trig4;
    assign o_done_res    = r_done4;
    assign o_expired     = r_tout4;
    assign o_distance_cm = r_dist4;

endmodule

### verif/echo_ranger_checker.sv
module echo_ranger_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_tick,
    input  logic                           i_start_req,
    input  logic                           i_echo,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_trig,
    input  logic                           i_done_res,
    input  logic                           i_expired,
    input  logic [uer_pkg::DIST_WIDTH-1:0] i_distance_cm,
    input  logic                           i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uer_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    output int                             o_fail_cnt,
    output int                             o_pending,
    output int                             o_done_cnt,
    output int                             o_tout_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                           trig;
        logic                           done;
        logic                           tout;
        logic [uer_pkg::DIST_WIDTH-1:0] cm_val;
    } t_reading;

    // Own copy of the sequencer state and of the four registers.
    uer_pkg::t_phase                 ph;
    logic [uer_pkg::TRIG_WIDTH-1:0]  ph_cnt;
    logic [uer_pkg::TRIG_WIDTH-1:0]  lo_ticks;
    logic [uer_pkg::TRIG_WIDTH-1:0]  hi_ticks;
    logic [uer_pkg::TIMER_WIDTH-1:0] elapsed;
    logic [uer_pkg::TIMER_WIDTH-1:0] width;
    logic [uer_pkg::TIMER_WIDTH-1:0] echo_lim;
    logic [uer_pkg::TIMER_WIDTH-1:0] idle_lim;
    logic                            seen_high;

    t_reading pending_readings[$];
    t_reading want;
    t_reading exp_r;
    int       fails;
    int       n_done;
    int       n_tout;

    function automatic logic [uer_pkg::DIST_WIDTH-1:0] width_to_cm(
        input logic [uer_pkg::TIMER_WIDTH-1:0] w);
        logic [31:0] cm;
        cm = (32'(w) * 32'd17) / 32'd1000;
        return (cm > 32'd65535) ? 16'hFFFF : cm[uer_pkg::DIST_WIDTH-1:0];
    endfunction

    task automatic advance_ranger(input logic tk, input logic st, input logic ec,
                                  output t_reading r);
        logic [uer_pkg::TRIG_WIDTH-1:0] lim;
        logic                           sat;
        r = '0;
        if (ph == uer_pkg::PH_IDLE) begin
            if (st) begin
                ph     = uer_pkg::PH_LOW;
                ph_cnt = '0;
            end
        end else if (tk) begin
            if (ph != uer_pkg::PH_MEASURE) begin
                // A length of zero still costs one tick, as the count is bumped first.
                lim = (ph == uer_pkg::PH_LOW) ? lo_ticks : hi_ticks;
                if (ph_cnt != uer_pkg::COUNT_MAX) ph_cnt = ph_cnt + 1'b1;
                if (ph_cnt >= lim) begin
                    ph_cnt = '0;
                    if (ph == uer_pkg::PH_LOW) begin
                        ph = uer_pkg::PH_HIGH;
                    end else begin
                        ph        = uer_pkg::PH_MEASURE;
                        elapsed   = '0;
                        width     = '0;
                        seen_high = 1'b0;
                    end
                end
            end else begin
                if (elapsed != uer_pkg::TIMER_MAX) elapsed = elapsed + 1'b1;
                sat = (elapsed == uer_pkg::TIMER_MAX);
                if (ec) begin
                    // The first high tick of the pulse is never tested against the limit.
                    if (!seen_high) begin
                        seen_high = 1'b1;
                        width     = uer_pkg::TIMER_WIDTH'(1);
                        r.tout    = sat;
                    end else begin
                        if (width != uer_pkg::TIMER_MAX) width = width + 1'b1;
                        r.tout = sat || (elapsed >= echo_lim);
                    end
                end else if (sat || (elapsed >= idle_lim)) begin
                    r.tout = 1'b1;
                end else if (seen_high) begin
                    r.done   = 1'b1;
                    r.cm_val = width_to_cm(width);
                end
                if (r.tout) begin
                    r.done   = 1'b1;
                    r.cm_val = '0;
                end
                if (r.done) begin
                    ph        = uer_pkg::PH_IDLE;
                    ph_cnt    = '0;
                    seen_high = 1'b0;
                end
            end
        end
        r.trig = (ph == uer_pkg::PH_HIGH);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph        = uer_pkg::PH_IDLE;
            ph_cnt    = '0;
            elapsed   = '0;
            width     = '0;
            seen_high = 1'b0;
            lo_ticks  = 8'd2;
            hi_ticks  = 8'd10;
            echo_lim  = 22'd39000;
            idle_lim  = 22'd3801000;
            pending_readings.delete();
            fails     = 0;
            n_done    = 0;
            n_tout    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    uer_pkg::REG_TRIG_LOW:  lo_ticks = i_cfg_data[uer_pkg::TRIG_WIDTH-1:0];
                    uer_pkg::REG_TRIG_HIGH: hi_ticks = i_cfg_data[uer_pkg::TRIG_WIDTH-1:0];
                    uer_pkg::REG_ECHO_TO:   echo_lim = i_cfg_data[uer_pkg::TIMER_WIDTH-1:0];
                    uer_pkg::REG_IDLE_TO:   idle_lim = i_cfg_data[uer_pkg::TIMER_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    $error("result word arrived with no expectation waiting");
                    fails++;
                end else begin
                    exp_r = pending_readings.pop_front();
                    if (i_trig !== exp_r.trig) begin
                        $error("trig: expected %0d, actual %0d", exp_r.trig, i_trig);
                        fails++;
                    end
                    if (i_done_res !== exp_r.done) begin
                        $error("done_res: expected %0d, actual %0d", exp_r.done, i_done_res);
                        fails++;
                    end
                    if (i_expired !== exp_r.tout) begin
                        $error("expired: expected %0d, actual %0d", exp_r.tout, i_expired);
                        fails++;
                    end
                    if (i_distance_cm !== exp_r.cm_val) begin
                        $error("distance_cm: expected %0d, actual %0d", exp_r.cm_val,
                               i_distance_cm);
                        fails++;
                    end
                end
                if (i_done_res === 1'b1) n_done++;
                if (i_done_res === 1'b1 && i_expired === 1'b1) n_tout++;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_ranger(i_tick, i_start_req, i_echo, want);
                pending_readings.push_back(want);
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= pending_readings.size();
        o_done_cnt <= n_done;
        o_tout_cnt <= n_tout;
    end

endmodule

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_GUARD = 8000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           tick      = 1'b0;
    logic                           start_req = 1'b0;
    logic                           echo      = 1'b0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [uer_pkg::CFG_WIDTH-1:0]  cfg_data  = '0;

    logic                           in_stall;
    logic                           out_valid;
    logic                           trig;
    logic                           done_res;
    logic                           expired;
    logic [uer_pkg::DIST_WIDTH-1:0] distance_cm;

    int fail_cnt;
    int pending;
    int done_cnt;
    int tout_cnt;

    // Register values as last written, used to size the trigger preamble and the echo pulse.
    logic [uer_pkg::TRIG_WIDTH-1:0]  lo_ticks_q = 8'd2;
    logic [uer_pkg::TRIG_WIDTH-1:0]  hi_ticks_q = 8'd10;
    logic [uer_pkg::TIMER_WIDTH-1:0] idle_lim_q = 22'd3801000;

    int gap_pct    = 10;
    int stall_pct  = 10;
    int n_words    = 0;
    int n_settings = 0;

    always #2 clk = ~clk;

    ultrasonic_echo_ranger_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_tick       (tick),
        .i_start_req  (start_req),
        .i_echo       (echo),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_trig       (trig),
        .o_done_res   (done_res),
        .o_expired    (expired),
        .o_distance_cm(distance_cm),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    echo_ranger_checker ranger_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_tick       (tick),
        .i_start_req  (start_req),
        .i_echo       (echo),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_trig       (trig),
        .i_done_res   (done_res),
        .i_expired    (expired),
        .i_distance_cm(distance_cm),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_done_cnt   (done_cnt),
        .o_tout_cnt   (tout_cnt)
    );

    // Offers one word, with an occasional burst of idle cycles ahead of it, and returns
    // at the edge that accepts it.
    task automatic send_sample(input logic tk, input logic st, input logic ec);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        tick      <= tk;
        start_req <= st;
        echo      <= ec;
        do @(posedge clk); while (in_stall);
        if (tk) n_words++;
    endtask

    // Writes all four registers once the pipeline has drained.
    task automatic program_ranger(input logic [uer_pkg::TRIG_WIDTH-1:0] lo,
                                  input logic [uer_pkg::TRIG_WIDTH-1:0] hi,
                                  input logic [uer_pkg::TIMER_WIDTH-1:0] echo_lim,
                                  input logic [uer_pkg::TIMER_WIDTH-1:0] idle_lim);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= uer_pkg::REG_TRIG_LOW;
        cfg_data <= uer_pkg::CFG_WIDTH'(lo);
        @(posedge clk);
        cfg_idx  <= uer_pkg::REG_TRIG_HIGH;
        cfg_data <= uer_pkg::CFG_WIDTH'(hi);
        @(posedge clk);
        cfg_idx  <= uer_pkg::REG_ECHO_TO;
        cfg_data <= echo_lim;
        @(posedge clk);
        cfg_idx  <= uer_pkg::REG_IDLE_TO;
        cfg_data <= idle_lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
        lo_ticks_q = lo;
        hi_ticks_q = hi;
        idle_lim_q = idle_lim;
        n_settings++;
    endtask

    // Sends n ticked words at the given echo level (2 for a random level), with untimed
    // words and the odd stray start request mixed in.
    task automatic drive_ticks(input int n, input int lvl);
        int   k;
        logic tk;
        k = 0;
        while (k < n) begin
            tk = ($urandom_range(0, 7) != 0);
            send_sample(tk, $urandom_range(0, 39) == 0,
                        (lvl == 2 || !tk) ? 1'($urandom_range(0, 1)) : 1'(lvl));
            if (tk) k++;
        end
    endtask

    // One measurement: start, the trigger preamble, a low stretch, an echo pulse, then low
    // words until a finished measurement comes out or TAIL_GUARD words have been sent.
    task automatic range_once();
        int base;
        int pre;
        int pulse;
        int r;
        int guard;
        base = done_cnt;
        pre  = ((lo_ticks_q == 0) ? 1 : lo_ticks_q) + ((hi_ticks_q == 0) ? 1 : hi_ticks_q);
        if ($urandom_range(0, 9) == 0) pre = $urandom_range(0, pre);
        send_sample(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
        drive_ticks(pre, 2);
        drive_ticks($urandom_range(0, 12), 0);
        r = $urandom_range(0, 99);
        if (r < 4)       pulse = 0;
        else if (r < 80) pulse = $urandom_range(1, 80);
        else if (r < 96) pulse = $urandom_range(81, 400);
        else             pulse = $urandom_range(401, 4000);
        if (pulse == 0 && idle_lim_q > 3000) pulse = 1;
        drive_ticks(pulse, 1);
        guard = 0;
        while (done_cnt == base && guard < TAIL_GUARD) begin
            send_sample($urandom_range(0, 4) != 0, 1'b0, 1'b0);
            guard++;
        end
    endtask

    function automatic logic [uer_pkg::TIMER_WIDTH-1:0] pick_limit();
        logic [uer_pkg::TIMER_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = uer_pkg::TIMER_WIDTH'(1);
            1:       v = uer_pkg::TIMER_MAX;
            2:       v = 22'd39000;
            3:       v = uer_pkg::TIMER_WIDTH'($urandom_range(1, 60));
            default: v = uer_pkg::TIMER_WIDTH'($urandom_range(60, 3000));
        endcase
        return v;
    endfunction

    initial begin
        forever begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #100ms;
        $display("ultrasonic_echo_ranger_unit verification failed");
        $finish;
    end

    initial begin
        logic [uer_pkg::TRIG_WIDTH-1:0] lo;
        logic [uer_pkg::TRIG_WIDTH-1:0] hi;
        int                             pct;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: idle words are ignored, start acts without a tick,
        // and a start while busy is dropped.
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        repeat (10) send_sample(1'b1, 1'b0, 1'b0);

        // The sequencer is now measuring; zero limits and zero phase lengths take hold
        // at once.
        program_ranger(8'd0, 8'd0, 22'd0, 22'd0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);

        // A one-tick pulse reports a distance of zero.
        program_ranger(8'd0, 8'd0, 22'd0, 22'd3);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);

        while (n_words < 1700) begin
            case ($urandom_range(0, 9))
                0:       lo = 8'd0;
                1:       lo = 8'd255;
                default: lo = 8'($urandom_range(0, 6));
            endcase
            hi = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 8));
            if (n_settings == 3) hi = 8'd1;
            program_ranger(lo, hi, pick_limit(), pick_limit());
            pct = $urandom_range(0, 2);
            gap_pct   = (pct == 0) ? 0 : ((pct == 1) ? 8 : 25);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            if (n_words > 1300) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            repeat ($urandom_range(3, 6)) begin
                repeat ($urandom_range(0, 3))
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                range_once();
            end
        end

        in_valid <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Drove %0d ticked words over %0d register settings.", n_words, n_settings + 1);
        $display("Checked %0d finished measurements, %0d of them ended by timeout.",
                 done_cnt, tout_cnt);
        if (fail_cnt == 0) begin
            $display("ultrasonic_echo_ranger_unit verification clean");
        end else begin
            $display("ultrasonic_echo_ranger_unit verification failed");
        end
        $finish;
    end

endmodule
